FILE: design/bdsl_pkg.sv
`timescale 1ns / 1ps

package bdsl_pkg;

    // Latched press event codes
    typedef enum logic [1:0]
    {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    // Configuration register indexes
    localparam logic [7:0] REG_DEBOUNCE_TICKS   = 8'd0;
    localparam logic [7:0] REG_LONG_PRESS_TICKS = 8'd1;

    localparam int DEBOUNCE_W = 10;
    localparam int LONG_W     = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
    localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd1000;

    // Active-low pin: released level
    localparam logic LEVEL_RELEASED = 1'b1;
    localparam logic LEVEL_PRESSED  = 1'b0;

endpackage

FILE: design/button_debounce_short_long_press_core.sv
`timescale 1ns / 1ps

// A tick request's result is registered and valid on the master side the next cycle.
// Throughput: one tick request per cycle; the single output register is refilled
// in the same cycle it is taken, so input stalls only while a result waits unread.
// Reset (rst_n low, asynchronous): level released, counters zero, press disarmed,
// no latched event, debounce_ticks 50, long_press_ticks 1000, no result pending.
module button_debounce_short_long_press_core
    import bdsl_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] pin_level, [1] take_event, [7:2] zero

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] event_res, [2] stable_level, [7:3] zero

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CMP_W = (COUNTER_WIDTH > LONG_W) ? COUNTER_WIDTH : LONG_W;

    logic [DEBOUNCE_W-1:0]    debounce_ticks_reg;
    logic [LONG_W-1:0]        long_press_ticks_reg;

    logic                     previous_raw_reg,    previous_raw_next;
    logic                     debounced_level_reg, debounced_level_next;
    logic [COUNTER_WIDTH-1:0] since_change_reg,    since_change_next;
    logic [COUNTER_WIDTH-1:0] press_elapsed_reg,   press_elapsed_next;
    logic                     press_armed_reg,     press_armed_next;
    press_event_t             event_latch_reg,     event_latch_next;
    press_event_t             event_res;

    logic                     out_valid_reg;
    logic [7:0]               out_data_reg;

    logic                     in_accept;
    logic                     raw;
    logic                     take;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign raw           = s_axis_tdata[0];
    assign take          = s_axis_tdata[1];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        previous_raw_next    = raw;
        debounced_level_next = debounced_level_reg;
        press_armed_next     = press_armed_reg;
        event_latch_next     = event_latch_reg;

        // Advance the press timer while armed, saturating
        press_elapsed_next = press_elapsed_reg;
        if (press_armed_reg && !(&press_elapsed_reg))
        begin
            press_elapsed_next = press_elapsed_reg + COUNTER_WIDTH'(1);
        end

        if (raw != previous_raw_reg)
        begin
            since_change_next = '0;
        end
        else if (&since_change_reg)
        begin
            since_change_next = since_change_reg;
        end
        else
        begin
            since_change_next = since_change_reg + COUNTER_WIDTH'(1);
        end

        if (CMP_W'(since_change_next) > CMP_W'(debounce_ticks_reg))
        begin
            if (raw != debounced_level_reg)
            begin
                debounced_level_next = raw;
                if (raw == LEVEL_PRESSED)
                begin
                    press_armed_next   = 1'b1;
                    press_elapsed_next = '0;
                end
                else
                begin
                    if (press_armed_reg)
                    begin
                        event_latch_next = EV_SHORT;
                    end
                    press_armed_next = 1'b0;
                end
            end
            else if (debounced_level_reg == LEVEL_PRESSED && press_armed_reg &&
                     CMP_W'(press_elapsed_next) >= CMP_W'(long_press_ticks_reg))
            begin
                event_latch_next = EV_LONG;
                press_armed_next = 1'b0;
            end
        end

        // Report before consume
        event_res = event_latch_next;
        if (take)
        begin
            event_latch_next = EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_RESET;
            long_press_ticks_reg <= LONG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_data[DEBOUNCE_W-1:0];
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data[LONG_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_raw_reg    <= LEVEL_RELEASED;
            debounced_level_reg <= LEVEL_RELEASED;
            since_change_reg    <= '0;
            press_elapsed_reg   <= '0;
            press_armed_reg     <= 1'b0;
            event_latch_reg     <= EV_NONE;
        end
        else if (in_accept)
        begin
            previous_raw_reg    <= previous_raw_next;
            debounced_level_reg <= debounced_level_next;
            since_change_reg    <= since_change_next;
            press_elapsed_reg   <= press_elapsed_next;
            press_armed_reg     <= press_armed_next;
            event_latch_reg     <= event_latch_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= {5'd0, debounced_level_next, event_res};
        end
    end

endmodule
